### hdl/csc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the circle/segment collision pipeline
// no dependencies

package csc_pkg;

  // default coordinate width (signed Q12.4)
  localparam int COORD_BITS_DEF = 16;

  // load enables for the two register stages of the wide multiplier
  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } mul_ctl_t;

endpackage

### hdl/circle_segment_collision_top.sv
`timescale 1ns / 1ps
// circle versus line segment collision test, six-stage pipeline
// depends on csc_pkg and csc_wide_mul
//
// usage:
//   input channel (in_valid/in_ready) takes one query word: segment start and
//   end points, circle center and radius, all fixed point.
//   output channel (out_valid/out_ready) returns one word per query: colliding
//   is 1 when the circle touches or overlaps the segment.
// pipeline: the accepting edge loads the first stage (differences) and the
//   word moves on through products, sums, partial products, wide sum and
//   compare, after which its result is presented.
// throughput: one query per cycle while out_ready is high; every stage has
//   its own valid bit and the exact compare cross*cross <= r^2*|a|^2 runs
//   through a split multiplier that takes two of those stages.
// stall: when out_ready is low the result word holds; earlier stages keep
//   filling bubbles and in_ready drops only once every stage is occupied.
// reset: rst (synchronous, active high) clears all stage valid bits; no
//   result is presented until a new query is accepted.
// words leave in the order they were accepted, none dropped or repeated.

module circle_segment_collision_top #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [COORD_BITS-2:0] radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         colliding
);
  import csc_pkg::*;

  localparam int D      = COORD_BITS + 1;  // coordinate difference width
  localparam int P      = 2 * D;           // signed product width
  localparam int S      = 2 * D + 1;       // signed sum width
  localparam int W      = 2 * D;           // unsigned magnitude width
  localparam int R      = 2 * COORD_BITS - 2;
  localparam int NSTAGE = 6;

  // nearest point selection
  localparam logic [1:0] SEL_START = 2'd0;
  localparam logic [1:0] SEL_END   = 2'd1;
  localparam logic [1:0] SEL_CROSS = 2'd2;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  // stage 0 registers
  logic signed [D-1:0] ax0, ay0, bx0, by0, dx0, dy0;
  logic [COORD_BITS-2:0] rad0;
  // stage 1 registers
  logic signed [P-1:0] p_axx, p_ayy, p_axbx, p_ayby, p_axby, p_aybx;
  logic signed [P-1:0] p_bxx, p_byy, p_dxx, p_dyy;
  logic [R-1:0] r2_1;
  // stage 2 registers
  logic [W-1:0]        aa2, db2, de2;
  logic signed [S-1:0] ab2, cr2;
  logic [R-1:0]        r2_2;
  // stage 3 registers
  logic [1:0] sel3;
  logic       hit_start3, hit_end3;
  // stage 4 registers
  logic [1:0] sel4;
  logic       hit_start4, hit_end4;
  logic [2*W-1:0] cross_sq4, bound4;

  logic [W-1:0] cr_mag;
  logic [1:0]   sel_next;
  logic         cross_hit;
  mul_ctl_t     mul_ctl;

  // stage load enables: a stage loads when empty or when it drains forward
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: coordinate differences
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax0  <= D'(seg_end_x) - D'(seg_start_x);
      ay0  <= D'(seg_end_y) - D'(seg_start_y);
      bx0  <= D'(center_x) - D'(seg_start_x);
      by0  <= D'(center_y) - D'(seg_start_y);
      dx0  <= D'(center_x) - D'(seg_end_x);
      dy0  <= D'(center_y) - D'(seg_end_y);
      rad0 <= radius;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_axx  <= ax0 * ax0;
      p_ayy  <= ay0 * ay0;
      p_axbx <= ax0 * bx0;
      p_ayby <= ay0 * by0;
      p_axby <= ax0 * by0;
      p_aybx <= ay0 * bx0;
      p_bxx  <= bx0 * bx0;
      p_byy  <= by0 * by0;
      p_dxx  <= dx0 * dx0;
      p_dyy  <= dy0 * dy0;
      r2_1   <= R'(rad0) * R'(rad0);
    end
  end

  // stage 2: squared lengths, dot and cross products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      aa2  <= W'(p_axx) + W'(p_ayy);
      db2  <= W'(p_bxx) + W'(p_byy);
      de2  <= W'(p_dxx) + W'(p_dyy);
      ab2  <= S'(p_axbx) + S'(p_ayby);
      cr2  <= S'(p_axby) - S'(p_aybx);
      r2_2 <= r2_1;
    end
  end

  // stage 3: classify projection, endpoint tests, cross magnitude
  assign cr_mag = cr2[S-1] ? W'(-cr2) : W'(cr2);

  always_comb begin
    if (aa2 == '0 || ab2[S-1] || ab2 == '0) begin
      sel_next = SEL_START;
    end else if (aa2 <= W'(ab2)) begin
      sel_next = SEL_END;
    end else begin
      sel_next = SEL_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sel3       <= sel_next;
      hit_start3 <= db2 <= W'(r2_2);
      hit_end3   <= de2 <= W'(r2_2);
    end
  end

  // stages 3 and 4: cross squared and radius squared times length squared
  assign mul_ctl.pp_en  = en[3];
  assign mul_ctl.sum_en = en[4];

  csc_wide_mul #(.W(W)) u_cross_sq (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (cr_mag),
    .b   (cr_mag),
    .p   (cross_sq4)
  );

  csc_wide_mul #(.W(W)) u_bound (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (W'(r2_2)),
    .b   (aa2),
    .p   (bound4)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sel4       <= sel3;
      hit_start4 <= hit_start3;
      hit_end4   <= hit_end3;
    end
  end

  // stage 5: final compare and select
  assign cross_hit = cross_sq4 <= bound4;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      case (sel4)
        SEL_START: colliding <= hit_start4;
        SEL_END:   colliding <= hit_end4;
        default:   colliding <= cross_hit;
      endcase
    end
  end

  // no result word straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held middle stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v[3] && !en[3]) |=> (v[3] && $stable(sel3)))
    else $error("stalled stage lost its word");

  // a result only appears from an occupied previous stage
  a_rose_from_prev: assert property (@(posedge clk) disable iff (rst)
    $rose(v[NSTAGE-1]) |-> $past(v[NSTAGE-2]))
    else $error("result appeared without a source word");

  // an accepted query lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted query not captured");

endmodule

### hdl/csc_wide_mul.sv
`timescale 1ns / 1ps
// two-stage unsigned multiplier built from four half-width partial products
// depends on csc_pkg (mul_ctl_t)

module csc_wide_mul #(
  parameter int W = 34
) (
  input  logic                clk,
  input  csc_pkg::mul_ctl_t   ctl,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [2*W-1:0]      p
);
  import csc_pkg::*;

  localparam int H = (W + 1) / 2;
  localparam int F = 4 * H;

  logic [2*H-1:0] ae;
  logic [2*H-1:0] be;
  logic [2*H-1:0] pp_ll;
  logic [2*H-1:0] pp_lh;
  logic [2*H-1:0] pp_hl;
  logic [2*H-1:0] pp_hh;
  logic [F-1:0]   full;

  // pad operands to an even split
  assign ae = (2*H)'(a);
  assign be = (2*H)'(b);

  // partial products
  always_ff @(posedge clk) begin
    if (ctl.pp_en) begin
      pp_ll <= ae[H-1:0]     * be[H-1:0];
      pp_lh <= ae[H-1:0]     * be[2*H-1:H];
      pp_hl <= ae[2*H-1:H]   * be[H-1:0];
      pp_hh <= ae[2*H-1:H]   * be[2*H-1:H];
    end
  end

  // recombine partial products
  assign full = {pp_hh, pp_ll} + (F'(pp_lh) << H) + (F'(pp_hl) << H);

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      p <= full[2*W-1:0];
    end
  end

endmodule

### sim/circle_segment_collision_checker.sv
`timescale 1ns / 1ps
// checker for the circle/segment collision pipeline: predicts each query's
// colliding bit, queues it and compares it against the result words in order
// depends on csc_pkg for the default coordinate width

module circle_segment_collision_checker #(
  parameter int CW = csc_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [CW-1:0] seg_start_x,
  input  logic signed [CW-1:0] seg_start_y,
  input  logic signed [CW-1:0] seg_end_x,
  input  logic signed [CW-1:0] seg_end_y,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic        [CW-2:0] radius,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 colliding,
  output int                   error_count,
  output int                   outstanding,
  output int                   checked_count,
  output int                   hit_count
);

  bit expected_colliding[$];
  bit oldest_hit;

  // exact geometry on wide signed words: clamp of the projection is decided
  // by the signs of a.b and |a|^2 - a.b, the interior case by cross products
  function automatic bit predict_colliding(
    input logic signed [CW-1:0] sx, sy, ex, ey, cx, cy,
    input logic        [CW-2:0] r
  );
    logic signed [127:0] ax, ay, bx, by, dx, dy, rr, aa, ab, cr;
    bit hit;
    ax = ex - sx;
    ay = ey - sy;
    bx = cx - sx;
    by = cy - sy;
    dx = cx - ex;
    dy = cy - ey;
    rr = r;
    rr = rr * rr;
    if (ax == 0 && ay == 0) begin
      // degenerate segment: distance to the start point
      hit = (bx * bx + by * by) <= rr;
    end else begin
      aa = ax * ax + ay * ay;
      ab = ax * bx + ay * by;
      if (ab <= 0) begin
        hit = (bx * bx + by * by) <= rr;
      end else if (aa <= ab) begin
        hit = (dx * dx + dy * dy) <= rr;
      end else begin
        cr = ax * by - ay * bx;
        hit = (cr * cr) <= (rr * aa);
      end
    end
    return hit;
  endfunction

  initial begin
    error_count   = 0;
    outstanding   = 0;
    checked_count = 0;
    hit_count     = 0;
  end

  // compare result words first, then queue the prediction for a new query
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (colliding) hit_count++;
        if (expected_colliding.size() == 0) begin
          error_count++;
          $display("%0t: result word with no query waiting: expected none actual %0b",
                   $time, colliding);
        end else begin
          oldest_hit = expected_colliding.pop_front();
          checked_count++;
          if (oldest_hit !== colliding) begin
            error_count++;
            $display("%0t: colliding expected %0b actual %0b", $time, oldest_hit, colliding);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_colliding.push_back(predict_colliding(seg_start_x, seg_start_y,
                                                       seg_end_x, seg_end_y,
                                                       center_x, center_y, radius));
      end
      outstanding = expected_colliding.size();
    end
  end

endmodule

### sim/circle_segment_collision_top_tb.sv
`timescale 1ns / 1ps
// testbench top for circle_segment_collision_top: clock, reset, query and
// result-side stimulus with random stalls, watchdog and verdict
// depends on csc_pkg, the block and circle_segment_collision_checker

module circle_segment_collision_top_tb;

  localparam int CW         = csc_pkg::COORD_BITS_DEF;
  localparam int N_RANDOM   = 530;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] seg_start_x = '0;
  logic signed [CW-1:0] seg_start_y = '0;
  logic signed [CW-1:0] seg_end_x = '0;
  logic signed [CW-1:0] seg_end_y = '0;
  logic signed [CW-1:0] center_x = '0;
  logic signed [CW-1:0] center_y = '0;
  logic        [CW-2:0] radius = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 colliding;

  int  error_count, outstanding, checked_count, hit_count;
  int  queries_sent;
  int  idle_cycles;
  bit  in_burst, out_burst;
  int  kind, ox, oy, span, len, d, along, r, t;
  int  sx, sy, ex, ey, cx, cy;

  always #2 clk = ~clk;

  circle_segment_collision_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .colliding  (colliding)
  );

  circle_segment_collision_checker #(.CW(CW)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .seg_start_x  (seg_start_x),
    .seg_start_y  (seg_start_y),
    .seg_end_x    (seg_end_x),
    .seg_end_y    (seg_end_y),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .colliding    (colliding),
    .error_count  (error_count),
    .outstanding  (outstanding),
    .checked_count(checked_count),
    .hit_count    (hit_count)
  );

  // symmetric random offset in [-s, s]
  function automatic int jitter(input int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // coordinate at or near the ends of the signed range
  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // present one query word after a random gap and hold it until accepted
  task automatic send_query(input int qsx, qsy, qex, qey, qcx, qcy, qr);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_start_x <= CW'(qsx);
    seg_start_y <= CW'(qsy);
    seg_end_x   <= CW'(qex);
    seg_end_y   <= CW'(qey);
    center_x    <= CW'(qcx);
    center_y    <= CW'(qcy);
    radius      <= (CW-1)'(qr);
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queries_sent++;
  endtask

  // stop sending until every queued result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, outstanding);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls per word, with stall-free stretches
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // query side: reset, directed cases, random geometry, drain, verdict
  initial begin
    queries_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // degenerate segment: inside, touching, just outside
    send_query(100, 100, 100, 100, 110, 100, 20);
    send_query(100, 100, 100, 100, 120, 100, 20);
    send_query(100, 100, 100, 100, 121, 100, 20);
    // projection before the start, touching then missing
    send_query(0, 0, 100, 0, -30, 40, 50);
    send_query(0, 0, 100, 0, -30, 40, 49);
    // projection past the end
    send_query(0, 0, 100, 0, 130, 40, 50);
    send_query(0, 0, 100, 0, 130, 40, 49);
    // interior, touching then missing
    send_query(0, 0, 100, 0, 50, 30, 30);
    send_query(0, 0, 100, 0, 50, 30, 29);
    // zero radius on and off the segment
    send_query(0, 0, 100, 0, 50, 0, 0);
    send_query(0, 0, 100, 0, 50, 1, 0);
    send_query(0, 0, 40, 40, 20, 20, 0);
    send_query(0, 0, 40, 40, 21, 20, 0);
    // full-range coordinates and radius
    send_query(-32768, -32768, 32767, 32767, -32768, 32767, 32767);
    send_query(-32768, -32768, 32767, 32767, 32767, -32768, 32767);
    send_query(-32768, -32768, 32767, 32767, 0, 0, 0);
    send_query(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
    send_query(-32768, -32768, -32768, -32768, -32768, -32768, 0);
    send_query(32767, 32767, 32767, -32768, 0, 0, 32767);
    send_query(-32768, 0, 32767, 0, 0, -32768, 32767);
    send_query(-32768, 0, 32767, 0, 0, 32767, 32767);
    send_query(32767, -32768, -32768, 32767, 32767, 32767, 0);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      kind = $urandom_range(0, 9);
      ox = int'($urandom_range(0, 56000)) - 28000;
      oy = int'($urandom_range(0, 56000)) - 28000;
      case (kind)
        0, 1: begin
          // unconstrained words
          sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
          cx = $urandom; cy = $urandom; r = $urandom;
        end
        6: begin
          // axis-aligned segment with the circle near tangency
          len   = $urandom_range(1, 3000);
          d     = $urandom_range(0, 3000);
          along = int'($urandom_range(0, 2 * len)) - len / 2;
          r     = d + int'($urandom_range(0, 2)) - 1;
          if (r < 0) r = 0;
          if ($urandom_range(0, 1)) d = -d;
          sx = ox; sy = oy; ex = ox + len; ey = oy; cx = ox + along; cy = oy + d;
          if ($urandom_range(0, 1)) begin
            t = sx; sx = sy; sy = t;
            t = ex; ex = ey; ey = t;
            t = cx; cx = cy; cy = t;
          end
          if ($urandom_range(0, 1)) begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
          end
        end
        7: begin
          // degenerate segment around the circle edge
          sx = ox; sy = oy; ex = ox; ey = oy;
          cx = ox + jitter(500); cy = oy + jitter(500);
          r  = $urandom_range(0, 710);
        end
        8: begin
          // zero radius at an endpoint, the midpoint or next to it
          d  = jitter(1000);
          t  = jitter(1000);
          sx = ox; sy = oy; ex = ox + 2 * d; ey = oy + 2 * t;
          case ($urandom_range(0, 3))
            0: begin cx = sx; cy = sy; end
            1: begin cx = ex; cy = ey; end
            2: begin cx = ox + d; cy = oy + t; end
            default: begin cx = ox + d + 1; cy = oy + t; end
          endcase
          r = 0;
        end
        9: begin
          // range extremes
          sx = pick_extreme(); sy = pick_extreme();
          ex = pick_extreme(); ey = pick_extreme();
          cx = pick_extreme(); cy = pick_extreme();
          case ($urandom_range(0, 2))
            0: r = 0;
            1: r = 32767;
            default: r = $urandom_range(0, 32767);
          endcase
        end
        default: begin
          // short segment with a nearby circle of similar size
          span = 1 << $urandom_range(2, 12);
          sx = ox + jitter(span); sy = oy + jitter(span);
          ex = ox + jitter(span); ey = oy + jitter(span);
          cx = ox + jitter(2 * span); cy = oy + jitter(2 * span);
          r  = $urandom_range(0, 2 * span);
        end
      endcase
      send_query(sx, sy, ex, ey, cx, cy, r);
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d queries and %0d checked result words, %0d colliding",
             queries_sent, checked_count, hit_count);
    $display("stimulus: directed edge cases, random geometry, stalls on both channels");
    if (error_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
